>>> design/aes192_cfb1_encrypt_macros.svh
// Assertion helpers for the top-level RTL file
`ifndef AES192_CFB1_ENCRYPT_MACROS_SVH
`define AES192_CFB1_ENCRYPT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define AESCFB_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define AESCFB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/aescfb_pkg.sv
package aescfb_pkg;

   // Configuration register indexes
   localparam logic [2:0] REG_KEY_LOW  = 3'd0;
   localparam logic [2:0] REG_KEY_MID  = 3'd1;
   localparam logic [2:0] REG_KEY_HIGH = 3'd2;
   localparam logic [2:0] REG_IV_LOW   = 3'd3;
   localparam logic [2:0] REG_IV_HIGH  = 3'd4;

   localparam int NUM_ROUNDS = 12;
   localparam int RK_ENTRIES = NUM_ROUNDS + 1;
   localparam int EXP_WORDS  = 4 * RK_ENTRIES;
   localparam int KEY_WORDS  = 6;

   // Round key expansion status towards the cipher sequencer
   typedef struct packed {
      logic busy;
   } kx_status_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // Reverse byte order of a 128-bit word
   function automatic logic [127:0] bswap128(input logic [127:0] v);
      logic [127:0] r;
      for (int k = 0; k < 16; k++) begin
         r[8*k +: 8] = v[8*(15-k) +: 8];
      end
      return r;
   endfunction

   // SubBytes, ShiftRows and (unless final round) MixColumns; byte n in bits 8n+7:8n
   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
      logic [7:0] sb [16];
      logic [7:0] t [16];
      logic [7:0] all;
      logic [127:0] o;
      for (int n = 0; n < 16; n++) begin
         sb[n] = SBOX[s[8*n +: 8]];
      end
      for (int c = 0; c < 4; c++) begin
         for (int row = 0; row < 4; row++) begin
            t[row + 4*c] = sb[row + 4*((c + row) % 4)];
         end
      end
      for (int c = 0; c < 4; c++) begin
         all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
         if (last) begin
            o[32*c      +: 8] = t[4*c];
            o[32*c + 8  +: 8] = t[4*c+1];
            o[32*c + 16 +: 8] = t[4*c+2];
            o[32*c + 24 +: 8] = t[4*c+3];
         end else begin
            o[32*c      +: 8] = t[4*c]   ^ all ^ xtime(t[4*c]   ^ t[4*c+1]);
            o[32*c + 8  +: 8] = t[4*c+1] ^ all ^ xtime(t[4*c+1] ^ t[4*c+2]);
            o[32*c + 16 +: 8] = t[4*c+2] ^ all ^ xtime(t[4*c+2] ^ t[4*c+3]);
            o[32*c + 24 +: 8] = t[4*c+3] ^ all ^ xtime(t[4*c+3] ^ t[4*c]);
         end
      end
      return o;
   endfunction

endpackage

>>> design/aescfb_keyexp.sv
module aescfb_keyexp (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [191:0]              key,
   input  logic [3:0]                rd_addr,
   output logic [127:0]              rd_data,
   output aescfb_pkg::kx_status_type status
);
   import aescfb_pkg::*;

   localparam logic [5:0] LAST_WORD = 6'(EXP_WORDS - 1);
   localparam logic [5:0] FIRST_GEN = 6'(KEY_WORDS);
   localparam logic [2:0] MOD_LAST  = 3'(KEY_WORDS - 1);

   logic [127:0]       mem [RK_ENTRIES];
   logic [127:0]       rd_data_ff;
   logic               busy_ff, busy_in;
   logic [5:0]         widx_ff, widx_in;
   logic [2:0]         mod6_ff, mod6_in;
   logic [7:0]         rcon_ff, rcon_in;
   logic [5:0][31:0]   win_ff, win_in;
   logic [3:0][31:0]   acc_ff, acc_in;
   logic [5:0][31:0]   key_words;
   logic [31:0]        prev_word, rot_word, sub_word, temp_word, new_word;

   assign key_words = key;
   assign prev_word = win_ff[5];
   assign rot_word  = {prev_word[7:0], prev_word[31:8]};

   // One new schedule word per cycle while the expansion is busy
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         sub_word[8*j +: 8] = SBOX[rot_word[8*j +: 8]];
      end
      temp_word = (mod6_ff == 3'd0) ? (sub_word ^ {24'd0, rcon_ff}) : prev_word;
      if (widx_ff < FIRST_GEN) begin
         new_word = key_words[widx_ff[2:0]];
      end else begin
         new_word = win_ff[0] ^ temp_word;
      end
   end

   // Sequencer next state
   always_comb begin
      busy_in = busy_ff;
      widx_in = widx_ff;
      mod6_in = mod6_ff;
      rcon_in = rcon_ff;
      win_in  = win_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         widx_in = '0;
         mod6_in = '0;
         rcon_in = 8'h01;
      end else if (busy_ff) begin
         win_in  = {new_word, win_ff[5:1]};
         acc_in[widx_ff[1:0]] = new_word;
         widx_in = widx_ff + 6'd1;
         mod6_in = (mod6_ff == MOD_LAST) ? 3'd0 : mod6_ff + 3'd1;
         if (mod6_ff == 3'd0 && widx_ff >= FIRST_GEN) begin
            rcon_in = xtime(rcon_ff);
         end
         if (widx_ff == LAST_WORD) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         widx_ff <= '0;
         mod6_ff <= '0;
         rcon_ff <= 8'h01;
      end else begin
         busy_ff <= busy_in;
         widx_ff <= widx_in;
         mod6_ff <= mod6_in;
         rcon_ff <= rcon_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      acc_ff <= acc_in;
   end

   // Round key store: a full entry is written every fourth word
   always_ff @(posedge clock) begin
      if (busy_ff && !start && widx_ff[1:0] == 2'd3) begin
         mem[widx_ff[5:2]] <= {new_word, acc_ff[2], acc_ff[1], acc_ff[0]};
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data     = rd_data_ff;
   assign status.busy = busy_ff;

endmodule

>>> design/aes192_cfb1_encrypt.sv
// AES-192 CFB-1 encryptor.
// req channel: one 128-bit plaintext block per transfer (tdata), tuser set marks the
// first block of a message and reloads the feedback register from the IV.
// rsp channel: one 128-bit ciphertext block per input block.
// csr channel: register writes (key low/mid/high, IV low/high); always ready.
// Each plaintext bit needs one full AES-192 encryption, run one round per cycle on a
// single shared round unit. rsp_tvalid rises once the last bit of the block is done;
// req_tready is low for the whole block and comes back as rsp_tvalid rises, so a new
// block is taken only after the previous one is finished.
// A key write starts a round key expansion (one also starts after reset), during which
// no block is taken. Reset clears the feedback register and key/IV registers to zero.
// If the receiver stalls, a finished result waits in the output register; the next
// block may still be taken and runs until its last bit, then holds until rsp is free.
`include "aes192_cfb1_encrypt_macros.svh"

module aes192_cfb1_encrypt (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // plaintext_low, plaintext_high
   input  logic         req_tuser,   // first_block
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // ciphertext_low, ciphertext_high
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_data
);
   import aescfb_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;
   localparam logic [3:0] LAST_RND = 4'(NUM_ROUNDS);
   localparam logic [6:0] LAST_BIT = 7'd127;

   logic          state_ff, state_in;
   logic [3:0]    rnd_ff, rnd_in;
   logic [6:0]    bit_ff, bit_in;
   logic [127:0]  sb_ff, sb_in;     // feedback register, byte 0 in the top bits
   logic [127:0]  pc_ff, pc_in;     // plaintext out at the top, ciphertext in at the bottom
   logic [127:0]  aes_ff, aes_in;
   logic [127:0]  rsp_data_ff, rsp_data_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          kick_ff;
   logic [63:0]   key_low_ff, key_mid_ff, key_high_ff, iv_low_ff, iv_high_ff;
   logic          csr_fire, req_fire, key_write, kx_start, out_free, cbit;
   logic [127:0]  rk_q, round_out, pc_next;
   kx_status_type kx_status;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign key_write = csr_fire && (csr_index == REG_KEY_LOW || csr_index == REG_KEY_MID
                                   || csr_index == REG_KEY_HIGH);
   assign kx_start  = kick_ff || key_write;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_mid_ff  <= '0;
         key_high_ff <= '0;
         iv_low_ff   <= '0;
         iv_high_ff  <= '0;
         kick_ff     <= 1'b1;
      end else begin
         kick_ff <= 1'b0;
         if (csr_fire) begin
            unique case (csr_index)
               REG_KEY_LOW:  key_low_ff  <= csr_data;
               REG_KEY_MID:  key_mid_ff  <= csr_data;
               REG_KEY_HIGH: key_high_ff <= csr_data;
               REG_IV_LOW:   iv_low_ff   <= csr_data;
               REG_IV_HIGH:  iv_high_ff  <= csr_data;
               default: ;
            endcase
         end
      end
   end

   aescfb_keyexp u_keyexp (
      .clock   (clock),
      .reset   (reset),
      .start   (kx_start),
      .key     ({key_high_ff, key_mid_ff, key_low_ff}),
      .rd_addr (rnd_in),
      .rd_data (rk_q),
      .status  (kx_status)
   );

   assign req_tready = (state_ff == ST_IDLE) && !kx_status.busy && !kick_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Shared round unit
   assign round_out = aes_round(aes_ff, rnd_ff == LAST_RND) ^ rk_q;
   assign cbit      = round_out[7] ^ pc_ff[127];
   assign pc_next   = {pc_ff[126:0], cbit};

   // Bit and round sequencer
   always_comb begin
      state_in     = state_ff;
      rnd_in       = rnd_ff;
      bit_in       = bit_ff;
      sb_in        = sb_ff;
      pc_in        = pc_ff;
      aes_in       = aes_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            rnd_in = '0;
            if (req_fire) begin
               state_in = ST_RUN;
               bit_in   = '0;
               pc_in    = bswap128(req_tdata);
               if (req_tuser) begin
                  sb_in = bswap128({iv_high_ff, iv_low_ff});
               end
            end
         end
         ST_RUN: begin
            priority if (rnd_ff == 4'd0) begin
               aes_in = bswap128(sb_ff) ^ rk_q;
               rnd_in = 4'd1;
            end else if (rnd_ff != LAST_RND) begin
               aes_in = round_out;
               rnd_in = rnd_ff + 4'd1;
            end else if (bit_ff != LAST_BIT || out_free) begin
               sb_in  = {sb_ff[126:0], cbit};
               pc_in  = pc_next;
               rnd_in = '0;
               bit_in = bit_ff + 7'd1;
               if (bit_ff == LAST_BIT) begin
                  rsp_data_in  = bswap128(pc_next);
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               // Last bit done but the result register is still full: hold
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rnd_ff       <= '0;
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         sb_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rnd_ff       <= rnd_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
         sb_ff        <= sb_in;
      end
   end

   always_ff @(posedge clock) begin
      pc_ff       <= pc_in;
      aes_ff      <= aes_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `AESCFB_ASSERT_NEXT(a_start_run, req_fire, state_ff == ST_RUN && rnd_ff == 4'd0 && bit_ff == 7'd0, "block start did not enter round zero")
   `AESCFB_ASSERT_IMPL(a_rnd_range, 1'b1, rnd_ff <= LAST_RND, "round counter out of range")
   `AESCFB_ASSERT_IMPL(a_no_run_expand, state_ff == ST_RUN, !kx_status.busy, "cipher running during key expansion")
   `AESCFB_ASSERT_IMPL(a_rsp_rise, $rose(rsp_valid_ff), $past(state_ff) == ST_RUN && $past(bit_ff) == LAST_BIT, "result raised before last bit")
   `AESCFB_ASSERT_NEXT(a_rsp_hold, rsp_valid_ff && !rsp_tready, rsp_valid_ff, "pending result dropped")

endmodule

>>> sim/tb_aes192_cfb1_encrypt.sv
module tb_aes192_cfb1_encrypt;
   import aescfb_pkg::*;

   // Ciphertext predictor and checker for the CFB-1 chain
   class cfb1_scoreboard;
      logic [63:0]  key_lo, key_mid, key_hi, iv_lo, iv_hi;
      logic [7:0]   rk [208];
      logic [7:0]   chain [16];
      logic [127:0] ct_queue [$];
      int           errors;

      function new();
         key_lo = '0; key_mid = '0; key_hi = '0; iv_lo = '0; iv_hi = '0;
         foreach (chain[k]) chain[k] = 8'h00;
         errors = 0;
         expand_key();
      endfunction

      function logic [7:0] mul2(logic [7:0] b);
         return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
      endfunction

      function void expand_key();
         logic [191:0] key;
         logic [7:0]   t [4];
         logic [7:0]   tmp;
         key = {key_hi, key_mid, key_lo};
         for (int k = 0; k < 24; k++) rk[k] = key[8*k +: 8];
         for (int i = KEY_WORDS; i < 52; i++) begin
            for (int j = 0; j < 4; j++) t[j] = rk[(i-1)*4 + j];
            if (i % KEY_WORDS == 0) begin
               tmp = t[0]; t[0] = t[1]; t[1] = t[2]; t[2] = t[3]; t[3] = tmp;
               for (int j = 0; j < 4; j++) t[j] = SBOX[t[j]];
               t[0] ^= 8'h01 << (i / KEY_WORDS - 1);
            end
            for (int j = 0; j < 4; j++) rk[i*4 + j] = rk[(i - KEY_WORDS)*4 + j] ^ t[j];
         end
      endfunction

      // Top bit of byte 0 of the AES-192 encryption of the chain register
      function logic keystream_bit();
         logic [7:0] s [16];
         logic [7:0] t [16];
         logic [7:0] all;
         for (int n = 0; n < 16; n++) s[n] = chain[n] ^ rk[n];
         for (int r = 1; r <= NUM_ROUNDS; r++) begin
            for (int n = 0; n < 16; n++) s[n] = SBOX[s[n]];
            for (int c = 0; c < 4; c++)
               for (int row = 0; row < 4; row++)
                  t[row + 4*c] = s[row + 4*((c + row) % 4)];
            for (int c = 0; c < 4; c++) begin
               all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
               for (int row = 0; row < 4; row++) begin
                  if (r == NUM_ROUNDS) s[4*c+row] = t[4*c+row];
                  else s[4*c+row] = t[4*c+row] ^ all
                                    ^ mul2(t[4*c+row] ^ t[4*c + (row+1)%4]);
               end
            end
            for (int n = 0; n < 16; n++) s[n] ^= rk[r*16 + n];
         end
         return s[0][7];
      endfunction

      function void write_reg(logic [2:0] idx, logic [63:0] val);
         case (idx)
            REG_KEY_LOW:  begin key_lo = val;  expand_key(); end
            REG_KEY_MID:  begin key_mid = val; expand_key(); end
            REG_KEY_HIGH: begin key_hi = val;  expand_key(); end
            REG_IV_LOW:   iv_lo = val;
            REG_IV_HIGH:  iv_hi = val;
            default: ;
         endcase
      endfunction

      // Accepted plaintext block: run 128 feedback steps, queue the ciphertext
      function void note_block(logic [127:0] pt, logic first);
         logic [127:0] iv;
         logic [127:0] ct;
         logic         cbit;
         int           pos;
         iv = {iv_hi, iv_lo};
         if (first) for (int k = 0; k < 16; k++) chain[k] = iv[8*k +: 8];
         ct = '0;
         for (int i = 0; i < 128; i++) begin
            pos = 8*(i/8) + 7 - (i%8);
            cbit = pt[pos] ^ keystream_bit();
            ct[pos] = cbit;
            for (int k = 0; k < 15; k++) chain[k] = {chain[k][6:0], chain[k+1][7]};
            chain[15] = {chain[15][6:0], cbit};
         end
         ct_queue.push_back(ct);
      endfunction

      function void check_block(logic [127:0] got);
         logic [127:0] want;
         if (ct_queue.size() == 0) begin
            $display("%0t: unexpected ciphertext %h", $time, got);
            errors++;
            return;
         end
         want = ct_queue.pop_front();
         if (got[63:0] !== want[63:0]) begin
            $display("%0t: ciphertext_low expected %h actual %h", $time, want[63:0], got[63:0]);
            errors++;
         end
         if (got[127:64] !== want[127:64]) begin
            $display("%0t: ciphertext_high expected %h actual %h",
                     $time, want[127:64], got[127:64]);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [63:0]  csr_data = '0;

   cfb1_scoreboard sb = new();
   int             blocks_sent = 0;

   aes192_cfb1_encrypt u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(50, 2500);
   endfunction

   task automatic idle_req(int n);
      repeat (n) begin
         @(negedge clock);
         req_tvalid = 1'b0;
      end
   endtask

   task automatic send_block(logic [127:0] pt, logic first);
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = pt;
      req_tuser  = first;
      do @(posedge clock); while (!req_tready);
      sb.note_block(pt, first);
      blocks_sent++;
   endtask

   task automatic csr_write(logic [2:0] idx, logic [63:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Drop valid, wait for every outstanding ciphertext plus one block time
   task automatic drain();
      idle_req(1);
      while (sb.ct_queue.size() != 0) @(posedge clock);
      repeat (1800) @(posedge clock);
   endtask

   // Receiver: ready runs, short stalls, the odd long stall
   initial begin
      int hold;
      int r;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) hold--;
         else begin
            r = $urandom_range(99);
            if (r < 55) begin
               rsp_tready = 1'b1; hold = $urandom_range(0, 3000);
            end else if (r < 95) begin
               rsp_tready = 1'b0; hold = $urandom_range(0, 5);
            end else begin
               rsp_tready = 1'b0; hold = $urandom_range(100, 3000);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_block(rsp_tdata);
   end

   initial begin
      #200_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      int len;
      int r;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Chain from the zero register after reset, no first block
      send_block('0, 1'b0);
      send_block('1, 1'b0);
      send_block({rand64(), rand64()}, 1'b0);
      drain();

      // All-ones key and IV; message of three blocks
      csr_write(REG_KEY_LOW, '1);
      csr_write(REG_KEY_MID, '1);
      csr_write(REG_KEY_HIGH, '1);
      csr_write(REG_IV_LOW, '1);
      csr_write(REG_IV_HIGH, '1);
      send_block('0, 1'b1);
      send_block('1, 1'b0);
      send_block({64'h8000_0000_0000_0001, 64'h0123_4567_89ab_cdef}, 1'b0);
      drain();

      // Key change mid-message, then the chain carries on
      csr_write(REG_KEY_MID, rand64());
      send_block({rand64(), rand64()}, 1'b0);
      drain();

      // IV change mid-message only counts on the next first block
      csr_write(REG_IV_LOW, '0);
      csr_write(REG_IV_HIGH, rand64());
      send_block({rand64(), rand64()}, 1'b0);
      send_block({rand64(), rand64()}, 1'b1);
      drain();

      // Unused indexes are ignored
      csr_write(3'd5, rand64());
      csr_write(3'd6, rand64());
      csr_write(3'd7, '1);
      send_block({rand64(), rand64()}, 1'b0);
      drain();

      // Zero key, random IV
      csr_write(REG_KEY_LOW, '0);
      csr_write(REG_KEY_MID, '0);
      csr_write(REG_KEY_HIGH, '0);
      csr_write(REG_IV_LOW, rand64());
      send_block('1, 1'b1);
      send_block('0, 1'b0);

      // Random messages, settings changed now and then between messages
      while (blocks_sent < 360) begin
         if ($urandom_range(39) == 0) begin
            drain();
            for (int i = 0; i < 8; i++) begin
               if ($urandom_range(2) != 0) begin
                  r = $urandom_range(9);
                  csr_write(3'(i), r == 0 ? 64'h0 : r == 1 ? '1 : rand64());
               end
            end
         end
         r = $urandom_range(99);
         if (r < 85) begin
            len = $urandom_range(1, 6);
            for (int b = 0; b < len; b++) begin
               send_block({rand64(), rand64()}, b == 0);
               idle_req(gap_len());
            end
         end else begin
            send_block({rand64(), rand64()}, $urandom_range(1));
            idle_req(gap_len());
         end
      end

      drain();
      if (sb.errors == 0 && sb.ct_queue.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
